### rtl/lmtc_pkg.sv
// Shared types, constants and the quarter-wave sine table of the transition compositor.
// Has no dependencies of its own. Used by lmtc_div, the top level and lmtc_checker.
package lmtc_pkg;

    localparam int LMTC_COLUMNS   = 32;
    localparam int LMTC_ROWS      = 8;
    localparam int CFG_INDEX_W    = 8;
    localparam int CFG_DATA_W     = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODE  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICKS = 8'd1;

    localparam logic [3:0]  MODE_RESET  = 4'd0;
    localparam logic [15:0] TICKS_RESET = 16'd100;

    localparam logic [3:0] MODE_FADE      = 4'd0;
    localparam logic [3:0] MODE_CURTAIN   = 4'd1;
    localparam logic [3:0] MODE_ZOOM      = 4'd2;
    localparam logic [3:0] MODE_ROTATE    = 4'd3;
    localparam logic [3:0] MODE_PIXELATE  = 4'd4;
    localparam logic [3:0] MODE_RIPPLE    = 4'd5;
    localparam logic [3:0] MODE_BLINK     = 4'd6;
    localparam logic [3:0] MODE_RELOAD    = 4'd7;
    localparam logic [3:0] MODE_CROSSFADE = 4'd8;

    localparam logic        KIND_LOAD    = 1'b0;
    localparam logic        KIND_COMPOSE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_ADDR,
        ST_READ,
        ST_COLOR
    } lmtc_state_t;

    localparam logic [14:0] SINE_Q14 [65] = '{
        15'd0, 15'd402, 15'd804, 15'd1205, 15'd1606, 15'd2006, 15'd2404, 15'd2801,
        15'd3196, 15'd3590, 15'd3981, 15'd4370, 15'd4756, 15'd5139, 15'd5520,
        15'd5897, 15'd6270, 15'd6639, 15'd7005, 15'd7366, 15'd7723, 15'd8076,
        15'd8423, 15'd8765, 15'd9102, 15'd9434, 15'd9760, 15'd10080, 15'd10394,
        15'd10702, 15'd11003, 15'd11297, 15'd11585, 15'd11866, 15'd12140,
        15'd12406, 15'd12665, 15'd12916, 15'd13160, 15'd13395, 15'd13623,
        15'd13842, 15'd14053, 15'd14256, 15'd14449, 15'd14635, 15'd14811,
        15'd14978, 15'd15137, 15'd15286, 15'd15426, 15'd15557, 15'd15679,
        15'd15791, 15'd15893, 15'd15986, 15'd16069, 15'd16143, 15'd16207,
        15'd16261, 15'd16305, 15'd16340, 15'd16364, 15'd16379, 15'd16384
    };

    // Sine of a/256 turn in Q1.14.
    function automatic logic signed [15:0] sin_q14(input logic [7:0] a);
        logic [6:0]  idx;
        logic [15:0] mag;
        begin
            idx = a[6] ? 7'(7'd64 - {1'b0, a[5:0]}) : {1'b0, a[5:0]};
            mag = {1'b0, SINE_Q14[idx]};
            sin_q14 = a[7] ? -$signed(mag) : $signed(mag);
        end
    endfunction

endpackage

### rtl/lmtc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Has no dependencies; holds one frame store per instance.
module lmtc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/lmtc_div.sv
// Progress divider: tick * 65536 / ticks, saturated at 1.0, four quotient bits a cycle.
// Depends on lmtc_pkg.
module lmtc_div
    import lmtc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] tick,
    input  logic [15:0] ticks,
    output logic        done,
    output logic [16:0] progress
);

    logic [15:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [15:0] div_reg;
    logic        sat_reg;
    logic [1:0]  cnt_reg;
    logic        busy_reg;

    // Four restoring steps; remainder stays below the divisor while tick is below ticks.
    always_comb
    begin
        logic [16:0] r2;
        logic [15:0] r;
        logic [15:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < 4; i++)
        begin
            r2 = {r, 1'b0};
            if (r2 >= {1'b0, div_reg})
            begin
                r2 = r2 - {1'b0, div_reg};
                q  = {q[14:0], 1'b1};
            end
            else
            begin
                q  = {q[14:0], 1'b0};
            end
            r = r2[15:0];
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= tick;
            quo_reg <= '0;
            div_reg <= ticks;
            sat_reg <= (tick >= ticks);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign progress = sat_reg ? 17'h10000 : {1'b0, quo_reg};

endmodule

### rtl/led_matrix_transition_compositor_top.sv
// Transition compositor for an RGB LED matrix: two frame stores and the mode datapath.
// Depends on lmtc_pkg, lmtc_ram and lmtc_div.
//
// A load request writes one pixel into both frame stores in the cycle it is taken and yields
// no result; the block is ready again at once. A compose request passes the progress divider
// (which takes the operands, then works four quotient bits a cycle), then the multiplier
// stage, address generation, the frame store read and the colour stage, and the pixel lands
// in the output register; the colour stage holds while an earlier pixel waits there untaken.
// One compose request is worked at a time and the input is ready again when the pixel lands,
// so no new compose request is taken before the last one is through. A finished pixel
// waiting in the output register does not stop the next request from being taken.
// Configuration writes are always accepted and must only be issued while no compose request
// is in flight. Frame store entries never loaded read as anything.
module led_matrix_transition_compositor_top
    import lmtc_pkg::*;
#(
    parameter int COLUMNS = LMTC_COLUMNS,
    parameter int ROWS    = LMTC_ROWS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   kind,
    input  logic [4:0]             column,
    input  logic [2:0]             row,
    input  logic [23:0]            old_color,
    input  logic [23:0]            new_color,
    input  logic [15:0]            tick,
    input  logic [7:0]             dice,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             red,
    output logic [7:0]             green,
    output logic [7:0]             blue,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PIXELS = COLUMNS * ROWS;
    localparam int AW     = $clog2(PIXELS);
    localparam int CX     = COLUMNS / 2;
    localparam int CY     = ROWS / 2;

    lmtc_state_t state_reg, state_next;

    logic [3:0]    mode_reg;
    logic [15:0]   ticks_reg;

    logic [6:0]    col_reg, row_reg;
    logic [7:0]    dice_reg;

    logic          div_done;
    logic [16:0]   p;
    logic          second;

    logic [33:0]        qq_reg;
    logic [24:0]        r255_reg;
    logic signed [25:0] zx_reg, zy_reg;
    logic signed [23:0] rxc_reg, rys_reg, rxs_reg, ryc_reg;
    logic [16:0]        span_reg;

    logic [AW-1:0] addr_reg, addr_next, load_addr;
    logic          sel_new_reg, sel_new_next;
    logic          black_reg, black_next;
    logic [7:0]    f_reg, frac_reg;

    logic [23:0]   old_q, new_q;
    logic          in_acc, load_we, out_load;
    logic [7:0]    red_next, green_next, blue_next;

    // Saturate a signed coordinate into [0, lim].
    function automatic logic [6:0] clamp_coord(input logic signed [25:0] v,
                                                input logic [6:0] lim);
        begin
            if (v < 0)
                clamp_coord = '0;
            else if (v > $signed({19'd0, lim}))
                clamp_coord = lim;
            else
                clamp_coord = v[6:0];
        end
    endfunction

    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign load_we   = in_acc && (kind == KIND_LOAD)
                       && (32'(column) < COLUMNS) && (32'(row) < ROWS);
    assign load_addr = AW'(32'(row) * 32'(COLUMNS) + 32'(column));

    // Configuration registers; writes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RESET;
            ticks_reg <= TICKS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MODE:  mode_reg  <= cfg_data[3:0];
                CFG_TICKS: ticks_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    lmtc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_acc && (kind == KIND_COMPOSE)),
        .tick     (tick),
        .ticks    (ticks_reg),
        .done     (div_done),
        .progress (p)
    );

    assign second = p[16] | p[15];

    lmtc_ram #(.WIDTH(24), .DEPTH(PIXELS)) u_old_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_addr),
        .wdata (old_color),
        .raddr (addr_reg),
        .rdata (old_q)
    );

    lmtc_ram #(.WIDTH(24), .DEPTH(PIXELS)) u_new_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_addr),
        .wdata (new_color),
        .raddr (addr_reg),
        .rdata (new_q)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_acc && (kind == KIND_COMPOSE)) state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_MUL;
            ST_MUL:   state_next = ST_ADDR;
            ST_ADDR:  state_next = ST_READ;
            ST_READ:  state_next = ST_COLOR;
            ST_COLOR: if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        out_load = (state_reg == ST_COLOR) && (!out_valid || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Hold the clamped position and the dice byte of the request.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            col_reg  <= (32'(column) >= COLUMNS) ? 7'(COLUMNS - 1) : {2'b00, column};
            row_reg  <= (32'(row) >= ROWS) ? 7'(ROWS - 1) : {4'b0000, row};
            dice_reg <= dice;
        end
    end

    // Multiplier stage: one product per register, nothing chained.
    always_ff @(posedge clk)
    begin
        logic [16:0]        qv;
        logic [16:0]        s;
        logic signed [23:0] dx24, dy24, sn24, cs24;
        logic signed [25:0] dx26, dy26, s26;
        logic [7:0]         a;
        if (state_reg == ST_MUL)
        begin
            qv   = second ? 17'({p, 1'b0} - 18'h10000 * 2 + 18'h10000 * 2
                                - {p, 1'b0} + 18'h20000 - {p, 1'b0})
                          : 17'({p, 1'b0});
            s    = second ? 17'({p, 1'b0} - 18'h10000) : 17'(18'h10000 - {p, 1'b0});
            a    = p[15:8];
            dx24 = 24'($signed({1'b0, col_reg}) - 8'(CX));
            dy24 = 24'($signed({1'b0, row_reg}) - 8'(CY));
            sn24 = 24'(sin_q14(a));
            cs24 = 24'(sin_q14(8'(a + 8'd64)));
            dx26 = 26'(dx24);
            dy26 = 26'(dy24);
            s26  = $signed({9'd0, s});
            qq_reg   <= 34'(qv) * 34'(qv);
            r255_reg <= 25'(p) * 25'd255;
            zx_reg   <= dx26 * s26;
            zy_reg   <= dy26 * s26;
            rxc_reg  <= dx24 * cs24;
            rys_reg  <= dy24 * sn24;
            rxs_reg  <= dx24 * sn24;
            ryc_reg  <= dy24 * cs24;
            span_reg <= s;
        end
    end

    // Address stage: pick the source frame, the blanking flag and the sample position for the mode.
    always_comb
    begin
        logic [6:0]         x, y;
        logic [23:0]        w;
        logic signed [25:0] zs;
        logic signed [23:0] v;
        logic [23:0]        mag;
        logic signed [25:0] t;
        logic [23:0]        rv;
        logic [17:0]        k3;
        x = col_reg;
        y = row_reg;
        sel_new_next = second;
        black_next   = 1'b0;
        w   = 24'(24'(CX) * 24'(p)) >> 16;
        k3  = 18'(p) * 18'd3;
        rv  = 24'(24'(COLUMNS) * 24'(span_reg)) >> 16;
        zs  = '0;
        v   = '0;
        mag = '0;
        t   = '0;
        case (mode_reg)
            MODE_FADE: ;
            MODE_CURTAIN:
                sel_new_next = (24'(col_reg) + w >= 24'(CX)) && (24'(col_reg) < 24'(CX) + w);
            MODE_ZOOM:
            begin
                zs = 26'(CX * 65536) + zx_reg;
                x  = clamp_coord(zs < 0 ? 26'sd0 : 26'(zs[25:16]), 7'(COLUMNS - 1));
                zs = 26'(CY * 65536) + zy_reg;
                y  = clamp_coord(zs < 0 ? 26'sd0 : 26'(zs[25:16]), 7'(ROWS - 1));
            end
            MODE_ROTATE:
            begin
                v   = rxc_reg - rys_reg;
                mag = v[23] ? 24'(-v) : 24'(v);
                t   = $signed({2'b00, mag >> 14});
                t   = (v[23] ? -t : t) + 26'(CX);
                x   = clamp_coord(t, 7'(COLUMNS - 1));
                v   = rxs_reg + ryc_reg;
                mag = v[23] ? 24'(-v) : 24'(v);
                t   = $signed({2'b00, mag >> 14});
                t   = (v[23] ? -t : t) + 26'(CY);
                y   = clamp_coord(t, 7'(ROWS - 1));
            end
            MODE_PIXELATE:
                sel_new_next = !({1'b0, dice_reg, 16'd0} > r255_reg);
            MODE_RIPPLE:
                sel_new_next = (col_reg[0] ^ row_reg[0]) ^ second;
            MODE_BLINK:
                black_next = k3[16];
            MODE_RELOAD:
                black_next = !(24'(col_reg) < rv);
            MODE_CROSSFADE: ;
            default:
                sel_new_next = 1'b1;
        endcase
        addr_next = AW'(32'(y) * 32'(COLUMNS) + 32'(x));
    end

    always_ff @(posedge clk)
    begin
        logic [41:0] fp;
        if (state_reg == ST_ADDR)
        begin
            fp = 42'(qq_reg) * 42'd255;
            addr_reg    <= addr_next;
            sel_new_reg <= sel_new_next;
            black_reg   <= black_next;
            f_reg       <= fp[39:32];
            frac_reg    <= r255_reg[23:16];
        end
    end

    // Colour stage: one 8 x 9 product per channel, shared by fade and crossfade.
    always_comb
    begin
        logic [23:0] src;
        logic [7:0]  c, o, n, d, res [3];
        logic [8:0]  m;
        logic [16:0] pr;
        src = sel_new_reg ? new_q : old_q;
        for (int k = 0; k < 3; k++)
        begin
            c  = src[16-8*k +: 8];
            o  = old_q[16-8*k +: 8];
            n  = new_q[16-8*k +: 8];
            d  = (n > o) ? 8'(n - o) : 8'(o - n);
            m  = (mode_reg == MODE_FADE) ? 9'(9'd256 - {1'b0, f_reg})
                                         : 9'({1'b0, frac_reg} + 9'd1);
            pr = 17'((mode_reg == MODE_FADE) ? c : d) * 17'(m);
            case (mode_reg)
                MODE_FADE:      res[k] = pr[15:8];
                MODE_CROSSFADE: res[k] = (n > o) ? 8'(o + pr[15:8]) : 8'(o - pr[15:8]);
                default:        res[k] = black_reg ? 8'd0 : c;
            endcase
        end
        red_next   = res[0];
        green_next = res[1];
        blue_next  = res[2];
    end

    // Output register: advance on load, drop valid once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (out_load)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            red   <= red_next;
            green <= green_next;
            blue  <= blue_next;
        end
    end

endmodule

### rtl/lmtc_checker.sv
// Port-level checks for the transition compositor, bound to the top level.
// Depends on lmtc_pkg and led_matrix_transition_compositor_top.
module lmtc_checker
    import lmtc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       kind,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] red,
    input logic       cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red))
        else $error("result dropped or changed while stalled");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_LOAD) && !out_valid |=> !out_valid)
        else $error("load request produced a result");

    a_compose_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_COMPOSE) |=> !in_ready)
        else $error("compose request not held busy");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without a compose request in flight");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port stalled");

endmodule

bind led_matrix_transition_compositor_top lmtc_checker u_lmtc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .cfg_ready (cfg_ready)
);
